// ----- rtl/core/lesf_pkg.sv -----
// Package for the largest empty square finder.
// Holds widths, register indexes, stage structs and a small helper function.
// No dependencies.
`timescale 1ns / 1ps

package lesf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_ROWS  = 65536;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SIDE_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int BYTE_W = 8;
  localparam int GW_W   = 11;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 1;

  localparam logic [IDX_W-1:0] REG_GRID_WIDTH    = 1'd0;
  localparam logic [IDX_W-1:0] REG_OBSTACLE_CHAR = 1'd1;

  localparam logic [GW_W-1:0]   GRID_WIDTH_RST    = 11'd1024;
  localparam logic [BYTE_W-1:0] OBSTACLE_CHAR_RST = 8'd111;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic             first;
    logic             blocked;
    logic             gate;
    logic             fwd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_ctl_t;

  typedef struct packed {
    logic              vld;
    logic [SIDE_W-1:0] side;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } res_t;

  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] row);
    logic [ROW_W-1:0] r;
    r = (row == ROW_W'(MAX_ROWS - 1)) ? row : row + ROW_W'(1);
    return r;
  endfunction

endpackage

// ----- rtl/core/lesf_line_buf.sv -----
// Line buffer: one entry per column, square side ending at that column.
// Synchronous write, registered read. Uses lesf_pkg.
`timescale 1ns / 1ps

module lesf_line_buf (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [lesf_pkg::COL_W-1:0]  wr_addr,
  input  logic [lesf_pkg::SIDE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [lesf_pkg::COL_W-1:0]  rd_addr,
  output logic [lesf_pkg::SIDE_W-1:0] rd_data
);
  import lesf_pkg::*;

  logic [SIDE_W-1:0] mem [MAX_WIDTH];
  logic [SIDE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/lesf_scan.sv -----
// Scan stage: configuration registers, row/column counters, fill count
// and read issue to the line buffer. Uses lesf_pkg.
`timescale 1ns / 1ps

module lesf_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lesf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lesf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        acc,
  input  logic [lesf_pkg::BYTE_W-1:0] cell_byte,
  input  logic                        last_cell,
  output lesf_pkg::cell_ctl_t         stage,
  output logic                        rd_en,
  output logic [lesf_pkg::COL_W-1:0]  rd_addr
);
  import lesf_pkg::*;

  logic [GW_W-1:0]   width_r;
  logic [BYTE_W-1:0] obst_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SIDE_W-1:0] fill_r, fill_nxt;
  cell_ctl_t         stage_r, stage_nxt;

  logic [SIDE_W-1:0] eff_w;
  logic              wrap_pre, wrap_post;
  logic [COL_W-1:0]  col_eff;
  logic [ROW_W-1:0]  row_eff;
  logic [SIDE_W-1:0] col_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= GRID_WIDTH_RST;
      obst_r  <= OBSTACLE_CHAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:    width_r <= GW_W'(cfg_wdata);
        REG_OBSTACLE_CHAR: obst_r  <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_w = SIDE_W'(1);
    end else if (width_r > GW_W'(MAX_WIDTH)) begin
      eff_w = SIDE_W'(MAX_WIDTH);
    end else begin
      eff_w = SIDE_W'(width_r);
    end

    wrap_pre  = SIDE_W'(col_r) >= eff_w;
    col_eff   = wrap_pre ? '0 : col_r;
    row_eff   = wrap_pre ? row_inc(row_r) : row_r;
    col_inc   = SIDE_W'(col_eff) + SIDE_W'(1);
    wrap_post = col_inc >= eff_w;

    col_nxt  = col_r;
    row_nxt  = row_r;
    fill_nxt = fill_r;
    if (acc) begin
      if (last_cell) begin
        col_nxt  = '0;
        row_nxt  = '0;
        fill_nxt = '0;
      end else begin
        col_nxt  = wrap_post ? '0 : col_inc[COL_W-1:0];
        row_nxt  = wrap_post ? row_inc(row_eff) : row_eff;
        fill_nxt = (col_inc > fill_r) ? col_inc : fill_r;
      end
    end

    stage_nxt.vld     = acc;
    stage_nxt.last    = last_cell;
    stage_nxt.first   = (col_eff == '0);
    stage_nxt.blocked = (cell_byte == obst_r);
    stage_nxt.gate    = SIDE_W'(col_eff) < fill_r;
    stage_nxt.fwd     = stage_r.vld && (stage_r.col == col_eff);
    stage_nxt.row     = row_eff;
    stage_nxt.col     = col_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      fill_r      <= '0;
      stage_r.vld <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      fill_r  <= fill_nxt;
      stage_r <= stage_nxt;
    end
  end

  assign stage   = stage_r;
  assign rd_en   = acc;
  assign rd_addr = col_eff;

endmodule

// ----- rtl/core/lesf_dp.sv -----
// Cell update stage: min of three neighbors plus one, line buffer write-back
// with forwarding, and tracking of the best square. Uses lesf_pkg.
`timescale 1ns / 1ps

module lesf_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lesf_pkg::cell_ctl_t         stage,
  input  logic [lesf_pkg::SIDE_W-1:0] rd_data,
  output logic                        wr_en,
  output logic [lesf_pkg::COL_W-1:0]  wr_addr,
  output logic [lesf_pkg::SIDE_W-1:0] wr_data,
  output lesf_pkg::res_t              snap
);
  import lesf_pkg::*;

  logic [SIDE_W-1:0] left_r, upleft_r;
  logic [SIDE_W-1:0] best_side_r, best_side_nxt;
  logic [ROW_W-1:0]  best_row_r, best_row_nxt;
  logic [COL_W-1:0]  best_col_r, best_col_nxt;

  logic [SIDE_W-1:0] up, left, upleft, m, here;
  logic              better;

  always_comb begin
    up     = stage.gate ? (stage.fwd ? left_r : rd_data) : '0;
    left   = stage.first ? '0 : left_r;
    upleft = stage.first ? '0 : upleft_r;
    m      = (up < left) ? up : left;
    m      = (m < upleft) ? m : upleft;
    here   = stage.blocked ? '0 : m + SIDE_W'(1);
    better = here > best_side_r;

    snap.vld  = stage.vld && stage.last;
    snap.side = better ? here      : best_side_r;
    snap.row  = better ? stage.row : best_row_r;
    snap.col  = better ? stage.col : best_col_r;

    best_side_nxt = best_side_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    if (stage.vld) begin
      if (stage.last) begin
        best_side_nxt = '0;
        best_row_nxt  = '0;
        best_col_nxt  = '0;
      end else begin
        best_side_nxt = snap.side;
        best_row_nxt  = snap.row;
        best_col_nxt  = snap.col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage.vld) begin
      left_r   <= here;
      upleft_r <= up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_side_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else begin
      best_side_r <= best_side_nxt;
      best_row_r  <= best_row_nxt;
      best_col_r  <= best_col_nxt;
    end
  end

  assign wr_en   = stage.vld;
  assign wr_addr = stage.col;
  assign wr_data = here;

endmodule

// ----- rtl/core/lesf_result.sv -----
// Result stage: holding slot for a finished grid and the output register.
// Turns the bottom right corner into the upper left one. Uses lesf_pkg.
`timescale 1ns / 1ps

module lesf_result (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lesf_pkg::res_t              snap,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [lesf_pkg::ROW_W-1:0]  out_top_row,
  output logic [lesf_pkg::COL_W-1:0]  out_left_col,
  output logic [lesf_pkg::SIDE_W-1:0] out_side,
  output logic                        fin_busy
);
  import lesf_pkg::*;

  res_t              fin_r, fin_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [COL_W-1:0]  left_r, left_nxt;
  logic [SIDE_W-1:0] side_r;

  logic              fin_go;
  logic [ROW_W:0]    row_sum;
  logic [SIDE_W:0]   col_sum, side_ext;
  logic [ROW_W:0]    side_row;

  always_comb begin
    fin_go = fin_r.vld && (!out_valid_r || !out_stall);

    fin_nxt     = snap.vld ? snap : fin_r;
    fin_nxt.vld = snap.vld || (fin_r.vld && !fin_go);

    out_valid_nxt = fin_go || (out_valid_r && out_stall);

    row_sum  = (ROW_W + 1)'(fin_r.row) + (ROW_W + 1)'(1);
    col_sum  = (SIDE_W + 1)'(fin_r.col) + (SIDE_W + 1)'(1);
    side_row = (ROW_W + 1)'(fin_r.side);
    side_ext = (SIDE_W + 1)'(fin_r.side);

    top_nxt  = '0;
    left_nxt = '0;
    if (fin_r.side != '0) begin
      if (row_sum >= side_row) begin
        top_nxt = ROW_W'(row_sum - side_row);
      end
      if (col_sum >= side_ext) begin
        left_nxt = COL_W'(col_sum - side_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r.vld   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      top_r  <= top_nxt;
      left_r <= left_nxt;
      side_r <= fin_r.side;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_top_row  = top_r;
  assign out_left_col = left_r;
  assign out_side     = side_r;
  assign fin_busy     = fin_r.vld;

endmodule

// ----- rtl/core/largest_empty_square_finder_unit.sv -----
// Channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// in       | in_valid, in_stall, in_cell_byte, ...   | word in
// out      | out_valid, out_stall, out_top_row, ...  | word out
// cfg      | cfg_we, cfg_index, cfg_wdata            | write only
//
// One cell per cycle while in_stall is low: the line buffer takes one read and one write per
// cycle. A grid's result passes the scan stage register, holding slot and output register.
// After the last cell of a grid, input may stall while its result moves out, and for as long
// as out_stall holds a waiting result word.
// Reset is synchronous; the line buffer needs no clearing pass (a fill count gates reads).
// Top level of the largest empty square finder. Uses lesf_pkg and the lesf_* modules.
`timescale 1ns / 1ps

module largest_empty_square_finder_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lesf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lesf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lesf_pkg::BYTE_W-1:0] in_cell_byte,
  input  logic                        in_last_cell,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lesf_pkg::ROW_W-1:0]  out_top_row,
  output logic [lesf_pkg::COL_W-1:0]  out_left_col,
  output logic [lesf_pkg::SIDE_W-1:0] out_side
);
  import lesf_pkg::*;

  cell_ctl_t         stage;
  res_t              snap;
  logic              acc, rd_en, wr_en, fin_busy, s1_last;
  logic [COL_W-1:0]  rd_addr, wr_addr;
  logic [SIDE_W-1:0] rd_data, wr_data;

  assign s1_last  = stage.vld && stage.last;
  assign in_stall = (out_valid && (fin_busy || s1_last)) || (fin_busy && s1_last);
  assign acc      = in_valid && !in_stall;

  lesf_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .cell_byte (in_cell_byte),
    .last_cell (in_last_cell),
    .stage     (stage),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  lesf_line_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lesf_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .snap    (snap)
  );

  lesf_result u_res (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap         (snap),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_top_row  (out_top_row),
    .out_left_col (out_left_col),
    .out_side     (out_side),
    .fin_busy     (fin_busy)
  );

endmodule

// ----- rtl/core/lesf_checker.sv -----
// Port-level checks for the largest empty square finder, bound to the top level.
// Uses lesf_pkg.
`timescale 1ns / 1ps

module lesf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lesf_pkg::ROW_W-1:0]  out_top_row,
  input logic [lesf_pkg::COL_W-1:0]  out_left_col,
  input logic [lesf_pkg::SIDE_W-1:0] out_side
);
  import lesf_pkg::*;

  a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_stall))
    else $error("input stall unknown while a word is offered");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_side) && $stable(out_top_row))
    else $error("stalled result word changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_side == '0) |-> (out_top_row == '0) && (out_left_col == '0))
    else $error("empty result carries a position");

  a_fits_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((SIDE_W + 1)'(out_left_col) + (SIDE_W + 1)'(out_side))
                  <= (SIDE_W + 1)'(MAX_WIDTH))
    else $error("square exceeds the row");

endmodule

bind largest_empty_square_finder_unit lesf_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_top_row  (out_top_row),
  .out_left_col (out_left_col),
  .out_side     (out_side)
);

// ----- dv/tb_largest_empty_square_finder_unit.sv -----
// Testbench for largest_empty_square_finder_unit: streams grids of cell words and checks each
// reported square against a behavioral line-buffer predictor kept in step with every accepted word.
// Depends on lesf_pkg and the RTL of the unit; needs nothing else.
`timescale 1ns / 1ps

module tb_largest_empty_square_finder_unit;
  import lesf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [ROW_W-1:0]  top_row;
    logic [COL_W-1:0]  left_col;
    logic [SIDE_W-1:0] side;
  } square_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = REG_GRID_WIDTH;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_cell_byte = '0;
  logic              in_last_cell = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ROW_W-1:0]  out_top_row;
  logic [COL_W-1:0]  out_left_col;
  logic [SIDE_W-1:0] out_side;

  // predictor state
  logic [GW_W-1:0]   gw_reg;
  logic [BYTE_W-1:0] obst_reg;
  logic [SIDE_W-1:0] above_sizes [MAX_WIDTH];
  int                left_run;
  int                diag_run;
  int                cur_col;
  int                cur_row;
  int                best_side;
  int                best_row;
  int                best_col;
  square_t           square_q[$];

  int send_gap_pct = 0;
  int out_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  largest_empty_square_finder_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_byte (in_cell_byte),
    .in_last_cell (in_last_cell),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_top_row  (out_top_row),
    .out_left_col (out_left_col),
    .out_side     (out_side)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d squares pending", cycles, square_q.size());
      $display("largest_empty_square_finder_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (out_stall_pct > 0) && ($urandom_range(99) < out_stall_pct);
  end

  function automatic void log_mismatch(input string what, input int exp_v, input int act_v);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
  endfunction

  always @(posedge clk) begin : check_squares
    square_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (square_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("square word with nothing pending: top %0d left %0d side %0d",
                   out_top_row, out_left_col, out_side);
      end else begin
        want = square_q.pop_front();
        if (out_top_row !== want.top_row) log_mismatch("top_row", want.top_row, out_top_row);
        if (out_left_col !== want.left_col) log_mismatch("left_col", want.left_col, out_left_col);
        if (out_side !== want.side) log_mismatch("side", want.side, out_side);
      end
    end
  end

  function automatic int eff_width();
    int w;
    w = gw_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic void clear_grid_state();
    foreach (above_sizes[i]) above_sizes[i] = '0;
    left_run = 0;
    diag_run = 0;
    cur_col = 0;
    cur_row = 0;
    best_side = 0;
    best_row = 0;
    best_col = 0;
  endfunction

  function automatic void row_advance();
    cur_col = 0;
    if (cur_row < MAX_ROWS - 1) cur_row++;
    left_run = 0;
    diag_run = 0;
  endfunction

  function automatic void predict_cell(input logic [BYTE_W-1:0] b, input logic last);
    int w;
    int up;
    int here;
    square_t sq;
    w = eff_width();
    if (cur_col >= w) row_advance();
    up = above_sizes[cur_col];
    if (b == obst_reg) begin
      here = 0;
    end else begin
      here = up;
      if (left_run < here) here = left_run;
      if (diag_run < here) here = diag_run;
      here = here + 1;
    end
    diag_run = up;
    above_sizes[cur_col] = SIDE_W'(here);
    left_run = here;
    if (here > best_side) begin
      best_side = here;
      best_row = cur_row;
      best_col = cur_col;
    end
    cur_col++;
    if (cur_col >= w) row_advance();
    if (last) begin
      sq = '0;
      if (best_side != 0) begin
        sq.side = SIDE_W'(best_side);
        if (best_row + 1 >= best_side) sq.top_row = ROW_W'(best_row + 1 - best_side);
        if (best_col + 1 >= best_side) sq.left_col = COL_W'(best_col + 1 - best_side);
      end
      square_q.push_back(sq);
      clear_grid_state();
    end
  endfunction

  task automatic send_cell(input logic [BYTE_W-1:0] b, input logic last);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_cell_byte <= b;
    in_last_cell <= last;
    do @(posedge clk); while (in_stall);
    predict_cell(b, last);
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++)
      send_cell(s[i], close && (i == s.len() - 1));
  endtask

  // drop valid, wait out pending squares and pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    while (square_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input int width, input int obstacle);
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_wdata <= CFG_W'(width);
    @(posedge clk);
    cfg_index <= REG_OBSTACLE_CHAR;
    cfg_wdata <= CFG_W'(obstacle);
    @(posedge clk);
    cfg_we <= 1'b0;
    gw_reg = GW_W'(width);
    obst_reg = BYTE_W'(obstacle);
  endtask

  task automatic test_reset_defaults();
    send_cell(8'h00, 1'b0);
    send_cell(8'hFF, 1'b0);
    send_cell(8'd111, 1'b0);
    send_cell(8'h78, 1'b1);
    settle();
  endtask

  task automatic test_no_empty_cell();
    configure(3, 0);
    repeat (5) send_cell(8'h00, 1'b0);
    send_cell(8'h00, 1'b1);
    settle();
    configure(2, 255);
    send_cell(8'hFF, 1'b0);
    send_cell(8'hFF, 1'b0);
    send_cell(8'h00, 1'b1);
    settle();
  endtask

  task automatic test_tie_break();
    configure(4, 111);
    send_text("..o...oooo..oo..", 1'b1);
    settle();
  endtask

  task automatic test_width_extremes();
    configure(0, 111);
    send_text("..o..", 1'b1);
    settle();
    configure(2047, 111);
    send_text("..o.", 1'b1);
    settle();
  endtask

  task automatic test_width_change_mid_row();
    configure(4, 111);
    send_text(".....", 1'b0);
    settle();
    configure(1, 46);
    send_text("a.a", 1'b1);
    settle();
  endtask

  task automatic test_full_width();
    configure(1024, 111);
    for (int i = 0; i < 48; i++)
      send_cell(($urandom_range(99) < 3) ? 8'd111 : 8'h2E, i == 47);
    settle();
  endtask

  task automatic test_random_grids(input int cell_budget);
    int sent;
    int w;
    int n;
    int pct;
    sent = 0;
    while (sent < cell_budget) begin
      if ($urandom_range(3) == 0) begin
        settle();
        w = ($urandom_range(15) == 0) ? $urandom_range(2047) : $urandom_range(1, 10);
        configure(w, $urandom_range(255));
      end
      w = eff_width();
      n = w * $urandom_range(1, 6);
      if (n > 60 || $urandom_range(7) == 0) n = $urandom_range(1, (n > 60) ? 60 : n);
      pct = 5 + 25 * $urandom_range(3);
      for (int i = 0; i < n; i++)
        send_cell(($urandom_range(99) < pct) ? obst_reg : BYTE_W'($urandom_range(255)),
                  i == n - 1);
      sent += n;
    end
    settle();
  endtask

  initial begin
    gw_reg = GRID_WIDTH_RST;
    obst_reg = OBSTACLE_CHAR_RST;
    clear_grid_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_no_empty_cell();
    test_tie_break();
    test_width_extremes();
    test_width_change_mid_row();
    test_full_width();
    test_random_grids(225);

    send_gap_pct = 80;
    test_random_grids(225);

    send_gap_pct = 0;
    out_stall_pct = 80;
    test_random_grids(225);

    send_gap_pct = 15;
    out_stall_pct = 15;
    test_random_grids(225);

    out_stall_pct = 0;
    settle();
    if (errors == 0 && square_q.size() == 0) begin
      $display("largest_empty_square_finder_unit verification clean");
    end else begin
      $display("largest_empty_square_finder_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lesf_pkg.sv
rtl/core/lesf_line_buf.sv
rtl/core/lesf_scan.sv
rtl/core/lesf_dp.sv
rtl/core/lesf_result.sv
rtl/core/largest_empty_square_finder_unit.sv
rtl/core/lesf_checker.sv
dv/tb_largest_empty_square_finder_unit.sv
